[design/dwpw_pkg.sv]
// Shared types and constants of the duty-windowed pulse waveform block.
`timescale 1ns / 1ps

package dwpw_pkg;

  // Reset value of the period registers, in ticks (truncated to the time width).
  localparam int unsigned PERIOD_RESET = 1000000;

  typedef enum logic [1:0] {
    OP_ADVANCE = 2'd0,
    OP_CHANGE  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    MODE_TRIANGLE = 2'd0,
    MODE_RISE     = 2'd1,
    MODE_FALL     = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_START  = 2'd1,
    CFG_DUTY   = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_idx_e;

  // Jobs of the shared multiply / divide unit.
  typedef enum logic [1:0] {
    UOP_MUL   = 2'd0,
    UOP_MOD   = 2'd1,
    UOP_RATIO = 2'd2
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_cmd_t;

endpackage

[design/dwpw_in_if.sv]
// Input channel of the waveform block: valid/ready and one command beat.
`timescale 1ns / 1ps

interface dwpw_in_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [TIME_BITS-1:0] elapsed_ticks;
  logic [TIME_BITS-1:0] new_period;

  modport source (output valid, output opcode, output elapsed_ticks, output new_period,
                  input ready);
  modport sink (input valid, input opcode, input elapsed_ticks, input new_period,
                output ready);
endinterface

[design/dwpw_out_if.sv]
// Output channel of the waveform block: valid/ready and one result beat.
`timescale 1ns / 1ps

interface dwpw_out_if #(
  parameter int unsigned FRAC_BITS = 16
);
  logic               valid;
  logic               ready;
  logic [FRAC_BITS:0] level;
  logic               looped_back;

  modport source (output valid, output level, output looped_back, input ready);
  modport sink (input valid, input level, input looped_back, output ready);
endinterface

[design/duty_windowed_pulse_waveform.sv]
// Top level of the duty-windowed pulse waveform generator.
`timescale 1ns / 1ps

// Phase accumulator for triangle and ramp light effects. Each input beat
// carries an opcode: advance adds elapsed_ticks to the phase, wraps it modulo
// the active period and returns one result beat (Q1.FRAC_BITS level plus a
// looped_back flag); change period rescales the phase offset and loads a new
// period; restart reloads start_period and puts the phase at the offset
// point. Only advance produces a result. All multiplies and divides run on
// one shared iterative unit, one bit per cycle, under a small sequencer, and
// the input is not ready while a command is in work. With T = TIME_BITS and
// F = FRAC_BITS, the modulo works over T + 1 dividend bits and each fraction
// multiply over F + 1 fraction bits; an advance whose level is zero skips the
// ratio divide. A finished result sits in an output register, so the next
// command is taken while that beat waits. Write the configuration only while
// the block is idle; a write lands at the next edge whatever the sequencer is
// doing.
module duty_windowed_pulse_waveform #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dwpw_pkg::cfg_idx_e cfg_idx_i,
  input  logic [((TIME_BITS > FRAC_BITS) ? TIME_BITS : FRAC_BITS + 1)-1:0] cfg_data_i,
  dwpw_in_if.sink            in_i,
  dwpw_out_if.source         out_o
);
  import dwpw_pkg::*;

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned FB = FRAC_BITS;
  localparam logic [FB:0]   FracOne   = {1'b1, {FB{1'b0}}};
  localparam logic [TB-1:0] PeriodRst = TB'(PERIOD_RESET);

  typedef enum logic [9:0] {
    S_IDLE         = 10'b0000000001,
    S_ADV_MOD      = 10'b0000000010,
    S_ADV_RATIO    = 10'b0000000100,
    S_ADV_OUT      = 10'b0000001000,
    S_CHG_MUL_NEW  = 10'b0000010000,
    S_CHG_MUL_OLD  = 10'b0000100000,
    S_CHG_MOD      = 10'b0001000000,
    S_CHG_MUL_DUTY = 10'b0010000000,
    S_RST_MUL_DUTY = 10'b0100000000,
    S_RST_MUL_OFF  = 10'b1000000000
  } state_e;

  // Configuration registers
  mode_e          mode_q;
  logic [TB-1:0]  start_per_q;
  logic [FB:0]    duty_q;
  logic [FB:0]    off_q;

  // Architectural state
  logic [TB-1:0]  phase_q, phase_d;
  logic [TB-1:0]  period_q, period_d;
  logic [TB-1:0]  window_q, window_d;

  // Sequencer control
  state_e         state_q, state_d;
  logic           issued_q, issued_d;
  logic           zero_q, zero_d;
  logic           out_valid_q, out_valid_d;

  // Work registers and output payload
  logic [TB-1:0]  opnd_q, opnd_d;
  logic [TB-1:0]  tmp_q, tmp_d;
  logic [TB:0]    div_q, div_d;
  logic           neg_q, neg_d;
  logic           loop_q, loop_d;
  logic [FB:0]    level_q, level_d;
  logic           out_loop_q, out_loop_d;

  // Shared unit hookup
  unit_cmd_t      cmd;
  logic [TB:0]    unit_a;
  logic [TB-1:0]  unit_b;
  logic [FB:0]    unit_f;
  logic           unit_done;
  logic [TB-1:0]  res_w;
  logic [FB+1:0]  quo_w;

  // Datapath helpers
  logic [FB:0]    duty_c;
  logic [FB:0]    off_c;
  logic [TB-1:0]  pcur;
  logic [TB-1:0]  start_fix;
  logic [TB-1:0]  new_fix;
  logic [TB:0]    sum_w;
  logic [TB+1:0]  v_w;
  logic [TB+1:0]  vneg_w;
  logic [TB-1:0]  wrap_w;
  logic [FB+1:0]  tri_w;
  logic [FB:0]    lvl_w;
  logic           in_acc;
  logic           unit_busy_state;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TRIANGLE;
      start_per_q <= PeriodRst;
      duty_q      <= FracOne;
      off_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q      <= mode_e'(cfg_data_i[1:0]);
        CFG_START:  start_per_q <= cfg_data_i[TB-1:0];
        CFG_DUTY:   duty_q      <= cfg_data_i[FB:0];
        CFG_OFFSET: off_q       <= cfg_data_i[FB:0];
        default:    ;
      endcase
    end
  end

  // Clamp fractions to one and zero periods to one tick.
  always_comb begin
    duty_c    = (duty_q > FracOne) ? FracOne : duty_q;
    off_c     = (off_q > FracOne) ? FracOne : off_q;
    pcur      = (period_q == '0) ? TB'(1) : period_q;
    start_fix = (start_per_q == '0) ? TB'(1) : start_per_q;
    new_fix   = (in_i.new_period == '0) ? TB'(1) : in_i.new_period;
    sum_w     = {1'b0, phase_q} + {1'b0, opnd_q};
    // Shifted phase for a period change; may go negative.
    v_w       = {2'b00, phase_q} + {2'b00, tmp_q} - {2'b00, res_w};
    vneg_w    = '0 - v_w;
    // Bring a negative remainder back into [0, period).
    wrap_w    = (neg_q && (res_w != '0)) ? (pcur - res_w) : res_w;
  end

  // Level from the window ratio u = floor(t * 2^(F+1) / D).
  always_comb begin
    tri_w = {FracOne, 1'b0} - quo_w;
    case (mode_q)
      MODE_TRIANGLE: lvl_w = (quo_w <= {1'b0, FracOne}) ? quo_w[FB:0] : tri_w[FB:0];
      MODE_RISE:     lvl_w = quo_w[FB+1:1];
      MODE_FALL:     lvl_w = FracOne - quo_w[FB+1:1];
      default:       lvl_w = '0;
    endcase
  end

  // Feed the shared unit from the state that owns it.
  always_comb begin
    cmd.op = UOP_MUL;
    unit_a = '0;
    unit_b = '0;
    unit_f = '0;
    unique case (state_q)
      S_ADV_MOD: begin
        cmd.op = UOP_MOD;
        unit_a = sum_w;
        unit_b = pcur;
      end
      S_ADV_RATIO: begin
        cmd.op = UOP_RATIO;
        unit_a = {1'b0, phase_q};
        unit_b = window_q;
      end
      S_CHG_MUL_NEW: begin
        unit_b = opnd_q;
        unit_f = off_c;
      end
      S_CHG_MUL_OLD: begin
        unit_b = pcur;
        unit_f = off_c;
      end
      S_CHG_MOD: begin
        cmd.op = UOP_MOD;
        unit_a = div_q;
        unit_b = pcur;
      end
      S_CHG_MUL_DUTY: begin
        unit_b = opnd_q;
        unit_f = duty_c;
      end
      S_RST_MUL_DUTY: begin
        unit_b = start_fix;
        unit_f = duty_c;
      end
      S_RST_MUL_OFF: begin
        unit_b = start_fix;
        unit_f = off_c;
      end
      default: ;
    endcase
    unit_busy_state = !((state_q == S_IDLE) || (state_q == S_ADV_OUT));
    cmd.start       = unit_busy_state && !issued_q;
  end

  assign in_acc = in_i.valid && (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    phase_d     = phase_q;
    period_d    = period_q;
    window_d    = window_q;
    opnd_d      = opnd_q;
    tmp_d       = tmp_q;
    div_d       = div_q;
    neg_d       = neg_q;
    loop_d      = loop_q;
    level_d     = level_q;
    out_loop_d  = out_loop_q;

    if (cmd.start) begin
      issued_d = 1'b1;
    end
    if (unit_done) begin
      issued_d = 1'b0;
    end
    // Drop the result beat once taken.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          opnd_d = (op_e'(in_i.opcode) == OP_CHANGE) ? new_fix : in_i.elapsed_ticks;
          case (op_e'(in_i.opcode))
            OP_ADVANCE: state_d = S_ADV_MOD;
            OP_CHANGE:  state_d = S_CHG_MUL_NEW;
            OP_RESTART: state_d = S_RST_MUL_DUTY;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_ADV_MOD: begin
        if (unit_done) begin
          phase_d = res_w;
          loop_d  = (sum_w > {1'b0, pcur});
          // Outside the window, empty window or unused mode: level is zero.
          if ((window_q == '0) || (res_w > window_q) ||
              !((mode_q == MODE_TRIANGLE) || (mode_q == MODE_RISE) ||
                (mode_q == MODE_FALL))) begin
            zero_d  = 1'b1;
            state_d = S_ADV_OUT;
          end else begin
            zero_d  = 1'b0;
            state_d = S_ADV_RATIO;
          end
        end
      end
      S_ADV_RATIO: begin
        if (unit_done) begin
          state_d = S_ADV_OUT;
        end
      end
      S_ADV_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          level_d     = zero_q ? '0 : lvl_w;
          out_loop_d  = loop_q;
          state_d     = S_IDLE;
        end
      end
      S_CHG_MUL_NEW: begin
        if (unit_done) begin
          tmp_d   = res_w;
          state_d = S_CHG_MUL_OLD;
        end
      end
      S_CHG_MUL_OLD: begin
        if (unit_done) begin
          neg_d   = v_w[TB+1];
          div_d   = v_w[TB+1] ? vneg_w[TB:0] : v_w[TB:0];
          state_d = S_CHG_MOD;
        end
      end
      S_CHG_MOD: begin
        if (unit_done) begin
          phase_d = wrap_w;
          state_d = S_CHG_MUL_DUTY;
        end
      end
      S_CHG_MUL_DUTY: begin
        if (unit_done) begin
          window_d = res_w;
          period_d = opnd_q;
          state_d  = S_IDLE;
        end
      end
      S_RST_MUL_DUTY: begin
        if (unit_done) begin
          window_d = res_w;
          state_d  = S_RST_MUL_OFF;
        end
      end
      S_RST_MUL_OFF: begin
        if (unit_done) begin
          // Offset of a whole period wraps to zero.
          phase_d  = (res_w == start_fix) ? '0 : res_w;
          period_d = start_fix;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
      period_q    <= PeriodRst;
      window_q    <= PeriodRst;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      period_q    <= period_d;
      window_q    <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q     <= opnd_d;
    tmp_q      <= tmp_d;
    div_q      <= div_d;
    neg_q      <= neg_d;
    loop_q     <= loop_d;
    level_q    <= level_d;
    out_loop_q <= out_loop_d;
  end

  dwpw_iter_unit #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (unit_a),
    .b_i    (unit_b),
    .f_i    (unit_f),
    .done_o (unit_done),
    .res_o  (res_w),
    .quo_o  (quo_w)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.level       = level_q;
  assign out_o.looped_back = out_loop_q;

endmodule

[design/dwpw_iter_unit.sv]
// Shared iterative unit: shift-add fraction multiply, restoring modulo and ratio divide.
`timescale 1ns / 1ps

module dwpw_iter_unit #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dwpw_pkg::unit_cmd_t  cmd_i,
  input  logic [TIME_BITS:0]   a_i,
  input  logic [TIME_BITS-1:0] b_i,
  input  logic [FRAC_BITS:0]   f_i,
  output logic                 done_o,
  output logic [TIME_BITS-1:0] res_o,
  output logic [FRAC_BITS+1:0] quo_o
);
  import dwpw_pkg::*;

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned SW = (TB + 1 > FB + 2) ? TB + 1 : FB + 2;
  localparam int unsigned CW = $clog2(SW);

  unit_op_e        op_q;
  logic            busy_q;
  logic            done_q;
  logic            first_q;
  logic [CW-1:0]   cnt_q;
  logic [CW-1:0]   last_cnt;
  logic [TB-1:0]   acc_q;
  logic [TB-1:0]   opnd_q;
  logic [SW-1:0]   sh_q;
  logic            low_q;

  logic            is_mul;
  logic            din;
  logic [TB:0]     rem2;
  logic [TB:0]     add_x;
  logic [TB:0]     add_y;
  logic [TB+1:0]   sum;
  logic            ge;

  // One adder serves both jobs: add for multiply, trial subtract for divide.
  always_comb begin
    is_mul = (op_q == UOP_MUL);
    din    = (op_q == UOP_MOD) ? sh_q[SW-1] : 1'b0;
    rem2   = first_q ? {1'b0, acc_q} : {acc_q, din};
    add_x  = is_mul ? {1'b0, acc_q} : rem2;
    add_y  = is_mul ? (sh_q[0] ? {1'b0, opnd_q} : '0) : ~{1'b0, opnd_q};
    sum    = {1'b0, add_x} + {1'b0, add_y} + {{(TB + 1){1'b0}}, !is_mul};
    ge     = sum[TB+1];
  end

  always_comb begin
    unique case (op_q)
      UOP_MUL:   last_cnt = CW'(FB);
      UOP_MOD:   last_cnt = CW'(TB);
      UOP_RATIO: last_cnt = CW'(FB + 1);
      default:   last_cnt = CW'(FB);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= UOP_MUL;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        op_q    <= cmd_i.op;
        busy_q  <= 1'b1;
        first_q <= (cmd_i.op == UOP_RATIO);
        cnt_q   <= '0;
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == last_cnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      opnd_q <= b_i;
      low_q  <= 1'b0;
      case (cmd_i.op)
        UOP_MUL: begin
          acc_q <= '0;
          sh_q  <= SW'(f_i);
        end
        UOP_MOD: begin
          acc_q <= '0;
          sh_q  <= SW'(a_i) << (SW - TB - 1);
        end
        default: begin
          acc_q <= a_i[TB-1:0];
          sh_q  <= '0;
        end
      endcase
    end else if (busy_q) begin
      if (is_mul) begin
        // Shift the product right; the last bit out is the lowest bit of the result.
        acc_q <= sum[TB:1];
        low_q <= sum[0];
        sh_q  <= sh_q >> 1;
      end else begin
        acc_q <= ge ? sum[TB-1:0] : rem2[TB-1:0];
        sh_q  <= {sh_q[SW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == UOP_MUL) ? {acc_q[TB-2:0], low_q} : acc_q;
  assign quo_o  = sh_q[FB+1:0];

endmodule

[bench/tb.sv]
// Self-checking testbench of the duty-windowed pulse waveform generator.
`timescale 1ns / 1ps

module tb;
  import dwpw_pkg::*;

  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;
  localparam logic [16:0] FRAC_MAX = 17'h1FFFF;

  // Codes the package leaves unnamed: the spare opcode and the spare effect mode.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // A change of period is the slowest beat without a result.
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned TAIL_CYCLES   = 150;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned HOLD_AFTER    = 150;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_BEATS   = 72;

  typedef struct packed {
    logic [16:0] level;
    logic        looped;
  } pulse_t;

  // One row of the directed part: a register write or a command beat. Where
  // the result can be read off by hand it is typed in; otherwise it is predicted.
  typedef struct packed {
    logic        is_cfg;
    cfg_idx_e    reg_idx;
    logic [31:0] value;     // register data, or elapsed ticks of a beat
    logic [1:0]  op;
    logic [31:0] period;    // new period of a change beat
    logic        known;
    logic [16:0] level;
    logic        looped;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  cfg_idx_e    cfg_idx_i;
  logic [31:0] cfg_data_i;

  dwpw_in_if  #(.TIME_BITS(TIME_BITS)) in_if ();
  dwpw_out_if #(.FRAC_BITS(FRAC_BITS)) out_if ();

  duty_windowed_pulse_waveform #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Waveform predictor: its own copy of the registers and of the phase state.
  // ---------------------------------------------------------------------------
  logic [1:0]      cfg_mode;
  logic [31:0]     cfg_start;
  logic [16:0]     cfg_duty;
  logic [16:0]     cfg_offset;
  longint unsigned phase_q;
  longint unsigned period_q;
  longint unsigned window_q;

  pulse_t      levels_due[$];
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  logic        long_hold_done = 1'b0;

  // Share of a tick count, floored; fractions above one count as one.
  function automatic longint unsigned share_of(longint unsigned ticks, logic [16:0] frac);
    longint unsigned f;
    f = (frac > FRAC_ONE) ? FRAC_ONE : longint'(frac);
    return (ticks * f) >> FRAC_BITS;
  endfunction

  function automatic longint unsigned usable_period(logic [31:0] p);
    return (p == 32'd0) ? 64'd1 : longint'(p);
  endfunction

  // Level at phase t: zero outside the window and for an empty window.
  function automatic logic [16:0] level_at(longint unsigned t);
    longint unsigned u;
    if (window_q == 0 || t > window_q) return '0;
    case (cfg_mode)
      MODE_TRIANGLE: begin
        u = (t << (FRAC_BITS + 1)) / window_q;
        return (u <= FRAC_ONE) ? 17'(u) : 17'(2 * FRAC_ONE - u);
      end
      MODE_RISE: return 17'((t << FRAC_BITS) / window_q);
      MODE_FALL: return 17'(FRAC_ONE - (t << FRAC_BITS) / window_q);
      default:   return '0;
    endcase
  endfunction

  function automatic void restart_waveform();
    period_q = usable_period(cfg_start);
    window_q = share_of(period_q, cfg_duty);
    phase_q  = share_of(period_q, cfg_offset) % period_q;
  endfunction

  function automatic void reset_waveform();
    cfg_mode   = MODE_TRIANGLE;
    cfg_start  = PERIOD_RESET;
    cfg_duty   = 17'(FRAC_ONE);
    cfg_offset = '0;
    restart_waveform();
    phase_q    = 0;
  endfunction

  // Apply one accepted command beat; only an advance yields a result.
  function automatic void step_waveform(input logic [1:0] op, input logic [31:0] ticks,
                                        input logic [31:0] new_p, output logic makes,
                                        output pulse_t res);
    longint unsigned sum;
    longint unsigned np;
    longint          shifted;
    makes = 1'b0;
    res   = '0;
    case (op)
      OP_ADVANCE: begin
        // A sum equal to the period wraps to zero but does not flag a loop.
        sum        = phase_q + longint'(ticks);
        res.looped = (sum > period_q);
        phase_q    = sum % period_q;
        res.level  = level_at(phase_q);
        makes      = 1'b1;
      end
      OP_CHANGE: begin
        // Shift by the move of the offset point, wrapped non-negative modulo
        // the old period; the phase may stay above the new period.
        np      = usable_period(new_p);
        shifted = longint'(phase_q) + longint'(share_of(np, cfg_offset))
                  - longint'(share_of(period_q, cfg_offset));
        shifted = shifted % longint'(period_q);
        if (shifted < 0) shifted = shifted + longint'(period_q);
        phase_q  = longint'(shifted);
        window_q = share_of(np, cfg_duty);
        period_q = np;
      end
      OP_RESTART: restart_waveform();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk_i) begin : result_check
    pulse_t due;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (levels_due.size() == 0) begin
        report_mismatch($sformatf("result beat level=%0d looped=%0b with none pending",
                                  out_if.level, out_if.looped_back));
      end else begin
        due = levels_due.pop_front();
        if (out_if.level !== due.level)
          report_mismatch($sformatf("level %0d, want %0d", out_if.level, due.level));
        if (out_if.looped_back !== due.looped)
          report_mismatch($sformatf("looped_back %0b, want %0b", out_if.looped_back,
                                    due.looped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a ready pattern that is drawn anew at random, and hold
  // off once for a long stretch so the block fills up and stops taking beats.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned slot;
    logic [15:0] pattern;
    slot    = 0;
    pattern = '1;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (slot % 48 == 0) begin
        case ($urandom_range(0, 3))
          0, 1:    pattern = '1;
          2:       pattern = 16'($urandom()) | 16'h0001;
          default: pattern = 16'h0101;
        endcase
      end
      out_if.ready <= pattern[slot % 16];
      slot++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat from the falling edge and hold it until it is taken.
  task automatic send_command(input logic [1:0] op, input logic [31:0] ticks,
                              input logic [31:0] new_p, input logic known,
                              input pulse_t typed);
    logic   makes;
    pulse_t res;
    @(negedge clk_i);
    in_if.valid         <= 1'b1;
    in_if.opcode        <= op;
    in_if.elapsed_ticks <= ticks;
    in_if.new_period    <= new_p;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    step_waveform(op, ticks, new_p, makes, res);
    if (makes) levels_due.push_back(known ? typed : res);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid, wait for every pending result, then let a beat without a
  // result run out before touching the registers.
  task automatic wait_idle(input int unsigned settle);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_MODE:   cfg_mode   = data[1:0];
      CFG_START:  cfg_start  = data;
      CFG_DUTY:   cfg_duty   = data[16:0];
      CFG_OFFSET: cfg_offset = data[16:0];
      default: ;
    endcase
  endtask

  // Period for a phase: tiny (many loops), moderate, anything, or an edge value.
  function automatic logic [31:0] pick_period(input int unsigned scale);
    case (scale)
      0: return 32'($urandom_range(1, 64));
      1: return 32'($urandom_range(65, 200000));
      2: return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return 32'd2;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [16:0] pick_fraction();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 17'(FRAC_ONE);
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  // One random beat, mostly advances sized to the period so the phase walks
  // through the window; the unused fields carry random bits as well.
  task automatic random_beat(input int unsigned scale);
    int unsigned     pick;
    int unsigned     sub;
    logic [31:0]     ticks;
    logic [31:0]     new_p;
    longint unsigned reach;
    pick  = $urandom_range(0, 99);
    ticks = $urandom();
    new_p = $urandom();
    if (pick < 76) begin
      sub = $urandom_range(0, 9);
      if (sub < 6) begin
        reach = 2 * period_q;
        if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
        ticks = $urandom_range(0, 32'(reach));
      end else if (sub < 8) begin
        // land exactly on the end of the period
        ticks = (phase_q <= period_q) ? 32'(period_q - phase_q) : 32'd0;
      end
      send_command(OP_ADVANCE, ticks, new_p, 1'b0, '0);
    end else if (pick < 88) begin
      if ($urandom_range(0, 4) != 0) new_p = pick_period(scale);
      send_command(OP_CHANGE, ticks, new_p, 1'b0, '0);
    end else if (pick < 96) begin
      send_command(OP_RESTART, ticks, new_p, 1'b0, '0);
    end else begin
      send_command(OP_UNUSED, ticks, new_p, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: after reset the period and window are 1000000 ticks and the
  // mode is triangle, so the first results follow by hand.
  // ---------------------------------------------------------------------------
  step_t plan [32];

  initial begin
    plan = '{
      '{1'b0, CFG_MODE,   32'd0,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd500000,     OP_ADVANCE,  32'd1,          1'b1, 17'd65536, 1'b0},
      '{1'b0, CFG_MODE,   32'd500000,     OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_CHANGE,   32'd2000000,    1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd1000000,    OP_ADVANCE,  32'd1,          1'b1, 17'd65536, 1'b0},
      '{1'b0, CFG_MODE,   32'd1000000,    OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'hFFFF_FFFF,  OP_ADVANCE,  32'd1,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_CHANGE,   32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd5,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b1},
      '{1'b0, CFG_MODE,   32'hA5A5_A5A5,  OP_UNUSED,   32'h5A5A_5A5A,  1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_MODE,   32'(MODE_RISE), OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_START,  32'd0,          OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_DUTY,   32'h1FFFF,      OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_OFFSET, 32'h1FFFF,      OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_RESTART,  32'd1,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd1,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b1, CFG_START,  32'hFFFF_FFFF,  OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_OFFSET, 32'd32768,      OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_MODE,   32'(MODE_FALL), OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_DUTY,   32'd0,          OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_RESTART,  32'd1,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b1, CFG_DUTY,   32'd65536,      OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_MODE,   32'(MODE_UNUSED), OP_ADVANCE, 32'd0,         1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd0,          OP_CHANGE,   32'hFFFF_FFFF,  1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'd1,          OP_ADVANCE,  32'd1,          1'b1, 17'd0,     1'b0},
      '{1'b1, CFG_MODE,   32'(MODE_TRIANGLE), OP_ADVANCE, 32'd0,       1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'h4000_0000,  OP_ADVANCE,  32'd1,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'hFFFF_FFFF,  OP_ADVANCE,  32'd1,          1'b0, 17'd0,     1'b0},
      '{1'b1, CFG_MODE,   32'(MODE_RISE), OP_ADVANCE,  32'd0,          1'b0, 17'd0,     1'b0},
      '{1'b0, CFG_MODE,   32'h1234_5678,  OP_ADVANCE,  32'd1,          1'b0, 17'd0,     1'b0}
    };
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed rows, random phases, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned scale;
    int unsigned burst_left;
    int unsigned gap;
    logic        beats_since_write;
    logic [1:0]  mode;
    logic [16:0] duty;
    logic [16:0] offset;
    pulse_t      typed;

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_MODE;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.opcode        = OP_ADVANCE;
    in_if.elapsed_ticks = '0;
    in_if.new_period    = '0;
    reset_waveform();
    burst_left        = 0;
    beats_since_write = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows back to back; register writes wait for an idle block.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (beats_since_write) wait_idle(SETTLE_CYCLES);
        beats_since_write = 1'b0;
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        typed.level  = plan[i].level;
        typed.looped = plan[i].looped;
        send_command(plan[i].op, plan[i].value, plan[i].period, plan[i].known, typed);
        beats_since_write = 1'b1;
      end
    end

    // Random phases: fresh settings, a restart to load them, then a run of
    // beats in bursts. The first phases pin the fraction extremes.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      scale = (ph < 4) ? ph : $urandom_range(0, 3);
      case (ph)
        0: begin mode = MODE_TRIANGLE; duty = 17'(FRAC_ONE); offset = '0;       end
        1: begin mode = MODE_FALL;     duty = FRAC_MAX;      offset = 17'(FRAC_ONE); end
        2: begin mode = MODE_RISE;     duty = 17'd1;         offset = FRAC_MAX; end
        default: begin
          mode   = ($urandom_range(0, 9) == 9) ? MODE_UNUSED : 2'($urandom_range(0, 2));
          duty   = pick_fraction();
          offset = pick_fraction();
        end
      endcase
      wait_idle(SETTLE_CYCLES);
      write_reg(CFG_MODE, 32'(mode));
      write_reg(CFG_START, pick_period(scale));
      write_reg(CFG_DUTY, 32'(duty));
      write_reg(CFG_OFFSET, 32'(offset));
      send_command(OP_RESTART, $urandom(), $urandom(), 1'b0, '0);

      for (int unsigned n = 0; n < PHASE_BEATS; n++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          idle_sender(gap);
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        // now and then hold until every pending result is back
        if ($urandom_range(0, 99) < 2) wait_idle(0);
        random_beat(scale);
      end
    end

    wait_idle(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin : watchdog
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
